[rtl/ascii_integer_token_parser_defines.svh]
// Assertion macros for the token parser checker.
// Each macro expects clk and rst_n in scope.
`ifndef ASCII_INTEGER_TOKEN_PARSER_DEFINES_SVH
`define ASCII_INTEGER_TOKEN_PARSER_DEFINES_SVH

// Same-cycle implication.
`define AITP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token parser check failed");

// Next-cycle implication.
`define AITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token parser check failed");

`endif

[rtl/aitp_pkg.sv]
`timescale 1ns / 1ps

package aitp_pkg;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int VALUE_W   = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_WIDTH = 1'b1;

    // Result width codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    // Classified byte, as handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_MINUS,
        OP_PLUS_SKIP,
        OP_FREEZE,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       eos;
    } entry_t;

    function automatic logic [VALUE_W-1:0] shape_value(
        input logic [VALUE_W-1:0] acc,
        input logic               neg,
        input logic               sgn,
        input logic [1:0]         wcode
    );
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] r;
        begin
            v = neg ? (VALUE_W'(0) - acc) : acc;
            unique case (wcode)
                WIDTH_8:  r = {{56{sgn & v[7]}}, v[7:0]};
                WIDTH_16: r = {{48{sgn & v[15]}}, v[15:0]};
                WIDTH_32: r = {{32{sgn & v[31]}}, v[31:0]};
                WIDTH_64: r = v;
            endcase
            shape_value = r;
        end
    endfunction

endpackage

[rtl/aitp_front.sv]
`timescale 1ns / 1ps

module aitp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               end_of_stream,
    input  logic               signed_mode,
    output logic               push_valid,
    input  logic               push_ready,
    output aitp_pkg::entry_t   push_entry
);

    logic in_token_reg;
    logic in_token_next;
    logic accept;
    logic is_end;
    logic is_blank;
    logic is_digit;
    logic keep;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    assign is_end   = (char_code == aitp_pkg::CH_SPACE) || (char_code == aitp_pkg::CH_CR)
                   || (char_code == aitp_pkg::CH_LF);
    assign is_blank = is_end || (char_code == aitp_pkg::CH_NUL)
                   || (char_code == aitp_pkg::CH_TAB);
    assign is_digit = (char_code >= aitp_pkg::CH_ZERO) && (char_code <= aitp_pkg::CH_NINE);

    // drop blanks between tokens
    assign keep       = in_token_reg || !is_blank;
    assign push_valid = in_valid && keep;

    always_comb
    begin
        push_entry.digit = char_code[3:0];
        push_entry.eos   = end_of_stream;
        if (in_token_reg && is_end)
        begin
            push_entry.op = aitp_pkg::OP_END;
        end
        else if (!in_token_reg && signed_mode && (char_code == aitp_pkg::CH_MINUS))
        begin
            push_entry.op = aitp_pkg::OP_MINUS;
        end
        else if (is_digit)
        begin
            push_entry.op = aitp_pkg::OP_DIGIT;
        end
        else if (signed_mode && (char_code == aitp_pkg::CH_PLUS))
        begin
            push_entry.op = aitp_pkg::OP_PLUS_SKIP;
        end
        else
        begin
            push_entry.op = aitp_pkg::OP_FREEZE;
        end
    end

    always_comb
    begin
        in_token_next = in_token_reg;
        if (accept)
        begin
            if (!in_token_reg)
            begin
                in_token_next = !is_blank && !end_of_stream;
            end
            else
            begin
                in_token_next = !is_end && !end_of_stream;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg <= 1'b0;
        end
        else
        begin
            in_token_reg <= in_token_next;
        end
    end

endmodule

[rtl/aitp_fifo.sv]
`timescale 1ns / 1ps

module aitp_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  aitp_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output aitp_pkg::entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aitp_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/aitp_back.sv]
`timescale 1ns / 1ps

module aitp_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  aitp_pkg::entry_t               pop_entry,
    input  logic                           signed_mode,
    input  logic [1:0]                     result_width_code,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [aitp_pkg::VALUE_W-1:0]   parsed_value,
    output logic                           was_negative
);

    localparam int W = aitp_pkg::VALUE_W;

    logic [W-1:0] acc_reg;
    logic [W-1:0] acc_next;
    logic         minus_reg;
    logic         minus_next;
    logic         frozen_reg;
    logic         frozen_next;
    logic [W-1:0] out_value_reg;
    logic [W-1:0] out_value_next;
    logic         out_neg_reg;
    logic         out_neg_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    logic [W-1:0] acc_upd;
    logic         minus_upd;
    logic         frozen_upd;
    logic         emits;
    logic         out_free;
    logic         fire;

    assign emits     = (pop_entry.op == aitp_pkg::OP_END) || pop_entry.eos;
    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = !emits || out_free;
    assign fire      = pop_valid && pop_ready;

    // times ten as shift-add, wraps at 64 bits
    always_comb
    begin
        acc_upd    = acc_reg;
        minus_upd  = minus_reg;
        frozen_upd = frozen_reg;
        case (pop_entry.op)
            aitp_pkg::OP_DIGIT:
            begin
                if (!frozen_reg)
                begin
                    acc_upd = (acc_reg << 3) + (acc_reg << 1) + W'(pop_entry.digit);
                end
            end
            aitp_pkg::OP_MINUS:  minus_upd  = 1'b1;
            aitp_pkg::OP_FREEZE: frozen_upd = 1'b1;
            default:
            begin
                acc_upd = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        minus_next     = minus_reg;
        frozen_next    = frozen_reg;
        out_value_next = out_value_reg;
        out_neg_next   = out_neg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fire)
        begin
            if (emits)
            begin
                out_value_next = acc_upd;
                out_neg_next   = minus_upd;
                out_valid_next = 1'b1;
                acc_next       = '0;
                minus_next     = 1'b0;
                frozen_next    = 1'b0;
            end
            else
            begin
                acc_next    = acc_upd;
                minus_next  = minus_upd;
                frozen_next = frozen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            minus_reg     <= 1'b0;
            frozen_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            minus_reg     <= minus_next;
            frozen_reg    <= frozen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_neg_reg   <= out_neg_next;
    end

    assign out_valid    = out_valid_reg;
    assign was_negative = out_neg_reg;
    // negate and fit to the selected width on the way out
    assign parsed_value = aitp_pkg::shape_value(out_value_reg, out_neg_reg, signed_mode,
                                                result_width_code);

endmodule

[rtl/ascii_integer_token_parser.sv]
`timescale 1ns / 1ps

// Decimal text to binary integer. Takes one ASCII byte per cycle, back to back, while
// the queue has room, and gives one 64-bit result per token (space, CR, LF or an
// end-of-stream byte closes a token). The front end classifies each byte in the cycle
// it is accepted and drops blanks between tokens; a queue of QUEUE_DEPTH words feeds
// the back end, whose times-ten-plus-digit add updates the running value at one word
// per cycle unless a closing word waits on a full output register. A result is held
// in an output register so input keeps flowing while it waits to be taken.
// signed_mode and result_width_code are to be written only while the block is idle.
module ascii_integer_token_parser
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [aitp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aitp_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          char_code,
    input  logic                                end_of_stream,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [aitp_pkg::VALUE_W-1:0]        parsed_value,
    output logic                                was_negative
);

    logic             signed_mode_reg;
    logic [1:0]       width_code_reg;
    logic             push_valid;
    logic             push_ready;
    aitp_pkg::entry_t push_entry;
    logic             pop_valid;
    logic             pop_ready;
    aitp_pkg::entry_t pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b1;
            width_code_reg  <= aitp_pkg::WIDTH_64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aitp_pkg::REG_SIGNED_MODE:  signed_mode_reg <= cfg_data[0];
                aitp_pkg::REG_RESULT_WIDTH: width_code_reg  <= cfg_data[1:0];
            endcase
        end
    end

    aitp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .end_of_stream (end_of_stream),
        .signed_mode   (signed_mode_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    aitp_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    aitp_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_entry         (pop_entry),
        .signed_mode       (signed_mode_reg),
        .result_width_code (width_code_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .parsed_value      (parsed_value),
        .was_negative      (was_negative)
    );

endmodule

[rtl/aitp_checker.sv]
`timescale 1ns / 1ps
`include "ascii_integer_token_parser_defines.svh"

module aitp_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_write,
    input logic [aitp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [aitp_pkg::CFG_DAT_W-1:0]   cfg_data,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [7:0]                       char_code,
    input logic                             end_of_stream,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [aitp_pkg::VALUE_W-1:0]     parsed_value,
    input logic                             was_negative
);

    logic       sgn_reg;
    logic [1:0] wcode_reg;
    logic       in_stall;
    logic       out_stall;
    logic       u8_out;
    logic       u32_out;
    logic       s16_out;

    // track the register settings seen on the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sgn_reg   <= 1'b1;
            wcode_reg <= aitp_pkg::WIDTH_64;
        end
        else if (cfg_write)
        begin
            if (cfg_index == aitp_pkg::REG_SIGNED_MODE)
            begin
                sgn_reg <= cfg_data[0];
            end
            if (cfg_index == aitp_pkg::REG_RESULT_WIDTH)
            begin
                wcode_reg <= cfg_data[1:0];
            end
        end
    end

    assign in_stall  = in_valid && !in_ready;
    assign out_stall = out_valid && !out_ready;
    assign u8_out    = out_valid && !sgn_reg && (wcode_reg == aitp_pkg::WIDTH_8);
    assign u32_out   = out_valid && !sgn_reg && (wcode_reg == aitp_pkg::WIDTH_32);
    assign s16_out   = out_valid && sgn_reg && (wcode_reg == aitp_pkg::WIDTH_16);

    `AITP_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable({char_code, end_of_stream}))

    `AITP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({parsed_value, was_negative}))

    `AITP_ASSERT_IMPLIES(a_u8_zero_ext, u8_out, parsed_value[63:8] == 56'd0)

    `AITP_ASSERT_IMPLIES(a_u32_zero_ext, u32_out, parsed_value[63:32] == 32'd0)

    `AITP_ASSERT_IMPLIES(a_s16_sign_ext, s16_out, (&parsed_value[63:15]) || !(|parsed_value[63:15]))

endmodule

bind ascii_integer_token_parser aitp_checker u_aitp_checker (.*);

[dv/ascii_integer_token_parser_checker.sv]
`timescale 1ns / 1ps

module ascii_integer_token_parser_checker
    import aitp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           char_code,
    input  logic                 end_of_stream,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [VALUE_W-1:0]   parsed_value,
    input  logic                 was_negative,
    output int                   mismatches,
    output int                   pending,
    output int                   tokens_checked
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               negative;
    } token_result_t;

    token_result_t      expected_tokens[$];

    logic               sign_mode_q  = 1'b1;
    logic [1:0]         width_code_q = WIDTH_64;

    logic               in_token   = 1'b0;
    logic               first_char = 1'b1;
    logic               minus_flag = 1'b0;
    logic               frozen     = 1'b0;
    logic [VALUE_W-1:0] running    = '0;

    function automatic logic [VALUE_W-1:0] fit_to_width(
        input logic [VALUE_W-1:0] acc,
        input logic               neg,
        input logic               sgn,
        input logic [1:0]         wcode
    );
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] mask;
        int                 bits;
        begin
            v    = neg ? (~acc + 64'd1) : acc;
            bits = 8 << wcode;
            if (bits < VALUE_W)
            begin
                mask = (64'd1 << bits) - 64'd1;
                v    = v & mask;
                if (sgn && v[bits-1])
                    v = v | ~mask;
            end
            return v;
        end
    endfunction

    task automatic close_token();
        token_result_t r;
        begin
            r.value    = fit_to_width(running, minus_flag, sign_mode_q, width_code_q);
            r.negative = minus_flag;
            expected_tokens.push_back(r);
            in_token   = 1'b0;
            first_char = 1'b1;
            minus_flag = 1'b0;
            frozen     = 1'b0;
            running    = '0;
        end
    endtask

    task automatic parse_word(input logic [7:0] c, input logic eos);
        logic ends;
        begin
            ends = (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
            if (!in_token)
            begin
                // drop blanks between tokens
                if (ends || c == CH_NUL || c == CH_TAB)
                    return;
                in_token   = 1'b1;
                first_char = 1'b1;
            end
            else if (ends)
            begin
                close_token();
                return;
            end

            if (first_char && sign_mode_q && c == CH_MINUS)
                minus_flag = 1'b1;
            else if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (!frozen)
                    running = running * 64'd10 + 64'(c - CH_ZERO);
            end
            else if (!(sign_mode_q && c == CH_PLUS))
                frozen = 1'b1;
            first_char = 1'b0;

            if (eos)
                close_token();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        token_result_t exp_r;
        if (!rst_n)
        begin
            sign_mode_q    = 1'b1;
            width_code_q   = WIDTH_64;
            in_token       = 1'b0;
            first_char     = 1'b1;
            minus_flag     = 1'b0;
            frozen         = 1'b0;
            running        = '0;
            expected_tokens.delete();
            mismatches     = 0;
            tokens_checked = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_SIGNED_MODE)
                    sign_mode_q = cfg_data[0];
                else if (cfg_index == REG_RESULT_WIDTH)
                    width_code_q = cfg_data[1:0];
            end

            if (in_valid && in_ready)
                parse_word(char_code, end_of_stream);

            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("parsed_value %h arrived with no token pending", parsed_value);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_tokens.pop_front();
                    if (parsed_value !== exp_r.value)
                    begin
                        $error("parsed_value expected %h actual %h", exp_r.value, parsed_value);
                        mismatches++;
                    end
                    if (was_negative !== exp_r.negative)
                    begin
                        $error("was_negative expected %b actual %b",
                               exp_r.negative, was_negative);
                        mismatches++;
                    end
                    tokens_checked++;
                end
            end

            pending = expected_tokens.size();
        end
    end

endmodule

[dv/ascii_integer_token_parser_tb.sv]
`timescale 1ns / 1ps

module ascii_integer_token_parser_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 48;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 8;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_write     = 1'b0;
    logic [aitp_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [aitp_pkg::CFG_DAT_W-1:0] cfg_data      = '0;
    logic                           in_valid      = 1'b0;
    logic                           in_ready;
    logic [7:0]                     char_code     = 8'h00;
    logic                           end_of_stream = 1'b0;
    logic                           out_valid;
    logic                           out_ready     = 1'b0;
    logic [aitp_pkg::VALUE_W-1:0]   parsed_value;
    logic                           was_negative;

    int                   mismatch_count;
    int                   pending_count;
    int                   tokens_checked;
    int                   words_sent    = 0;
    int                   cycle_count   = 0;
    bit                   gaps_on       = 1'b1;
    bit                   hold_request  = 1'b0;

    logic [7:0] blank_codes [5] = '{aitp_pkg::CH_SPACE, aitp_pkg::CH_TAB, aitp_pkg::CH_NUL,
                                    aitp_pkg::CH_CR, aitp_pkg::CH_LF};
    logic [7:0] end_codes   [3] = '{aitp_pkg::CH_SPACE, aitp_pkg::CH_CR, aitp_pkg::CH_LF};

    // {end_of_stream, char_code}
    logic [8:0] directed_words [25] = '{
        {1'b0, aitp_pkg::CH_TAB}, {1'b0, aitp_pkg::CH_NUL}, {1'b0, aitp_pkg::CH_SPACE},
        {1'b0, aitp_pkg::CH_LF}, {1'b1, aitp_pkg::CH_CR},
        {1'b1, aitp_pkg::CH_MINUS},
        {1'b0, aitp_pkg::CH_PLUS}, {1'b0, 8'h37}, {1'b0, aitp_pkg::CH_TAB}, {1'b0, 8'h39},
        {1'b0, aitp_pkg::CH_CR},
        {1'b0, 8'h31}, {1'b0, aitp_pkg::CH_MINUS}, {1'b0, 8'h32}, {1'b0, aitp_pkg::CH_LF},
        {1'b0, 8'h39}, {1'b0, 8'hFF}, {1'b1, 8'h39},
        {1'b0, 8'h34}, {1'b1, aitp_pkg::CH_SPACE},
        {1'b0, aitp_pkg::CH_MINUS}, {1'b0, 8'h31}, {1'b0, 8'h32}, {1'b0, 8'h38},
        {1'b0, aitp_pkg::CH_SPACE}
    };

    bit         phase_sign  [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [1:0] phase_width [NUM_PHASES] = '{aitp_pkg::WIDTH_64, aitp_pkg::WIDTH_8,
                                             aitp_pkg::WIDTH_8, aitp_pkg::WIDTH_64,
                                             aitp_pkg::WIDTH_16, aitp_pkg::WIDTH_32,
                                             aitp_pkg::WIDTH_32, aitp_pkg::WIDTH_16};

    ascii_integer_token_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .parsed_value  (parsed_value),
        .was_negative  (was_negative)
    );

    ascii_integer_token_parser_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .end_of_stream  (end_of_stream),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .parsed_value   (parsed_value),
        .was_negative   (was_negative),
        .mismatches     (mismatch_count),
        .pending        (pending_count),
        .tokens_checked (tokens_checked)
    );

    always #4 clk = ~clk;

    // Entered and left at a falling edge.
    task automatic send_word(input logic [7:0] c, input logic eos);
        begin
            while (gaps_on && $urandom_range(99) < 27)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid      <= 1'b1;
            char_code     <= c;
            end_of_stream <= eos;
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
            words_sent++;
        end
    endtask

    task automatic write_regs(input bit sgn, input logic [1:0] wcode);
        begin
            cfg_write <= 1'b1;
            cfg_index <= aitp_pkg::REG_SIGNED_MODE;
            cfg_data  <= aitp_pkg::CFG_DAT_W'(sgn);
            @(negedge clk);
            cfg_index <= aitp_pkg::REG_RESULT_WIDTH;
            cfg_data  <= wcode;
            @(negedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    task automatic send_token();
        int kind;
        int n_digits;
        int pick;
        int i;
        begin
            kind = $urandom_range(99);
            repeat ($urandom_range(2))
                send_word(blank_codes[$urandom_range(4)], 1'b0);
            if (kind < 15)
            begin
                // noise: raw bytes with random stream ends
                repeat ($urandom_range(1, 5))
                    send_word(8'($urandom_range(255)), 1'($urandom_range(9) == 0));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                    send_word(aitp_pkg::CH_MINUS, 1'b0);
                else if (pick < 35)
                    send_word(aitp_pkg::CH_PLUS, 1'b0);
                // long digit runs wrap the 64-bit accumulator
                n_digits = ($urandom_range(9) == 0) ? $urandom_range(18, 24)
                                                     : $urandom_range(1, 6);
                for (i = 0; i < n_digits; i++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 3)
                        send_word(aitp_pkg::CH_PLUS, 1'b0);
                    else if (pick < 6)
                        send_word(8'($urandom_range(255)), 1'b0);
                    else
                        send_word(aitp_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b0);
                end
                pick = $urandom_range(4);
                if (pick < 3)
                    send_word(end_codes[pick], 1'b0);
                else if (pick == 3)
                    send_word(end_codes[$urandom_range(2)], 1'b1);
                else
                    send_word(aitp_pkg::CH_ZERO + 8'($urandom_range(9)), 1'b1);
            end
        end
    endtask

    // Receiver, with one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= !gaps_on || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("run exceeded %0d cycles with %0d tokens pending", CYCLE_LIMIT, pending_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int p;
        int k;
        int phase_end;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_regs(1'b1, aitp_pkg::WIDTH_64);

        for (k = 0; k < 25; k++)
            send_word(directed_words[k][7:0], directed_words[k][8]);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // drain before touching the registers
            in_valid <= 1'b0;
            while (pending_count != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
            write_regs(phase_sign[p], phase_width[p]);

            gaps_on = (p != 3);
            if (p == 1)
                hold_request = 1'b1;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
                send_token();
            // close any open token
            send_word(aitp_pkg::CH_SPACE, 1'b0);
        end

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes over %0d register settings, %0d tokens compared.",
                 words_sent, NUM_PHASES + 1, tokens_checked);
        $display("Included a %0d-cycle output hold-off and a stretch with no idle cycles.",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
